>>> src/itemset_support_counter_defines.svh
// Assertion helpers for the itemset support counter.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef ITEMSET_SUPPORT_COUNTER_DEFINES_SVH
`define ITEMSET_SUPPORT_COUNTER_DEFINES_SVH

// Same-cycle implication.
`define ISC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("isc: same-cycle check failed");

// Next-cycle implication.
`define ISC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("isc: next-cycle check failed");

`endif

>>> src/isc_pkg.sv
package isc_pkg;

  // fixed field widths
  localparam int unsigned ID_W     = 16;
  localparam int unsigned CNT_W    = 24;
  localparam int unsigned PAT_W    = 3;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned LEN_IN_W = 4;
  localparam int unsigned PIU_W    = 4;

  // at most this many patterns are matched and reported
  localparam int unsigned REPORT_LIMIT = 8;

  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned S_TUSER_W = 3;
  localparam int unsigned M_TDATA_W = 56;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  localparam logic [PIU_W-1:0] PIU_RESET = 4'd1;

  // register index, taken from paddr[2]
  localparam logic REG_PATTERNS_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ITEM   = 2'd1,
    OP_REPORT = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

endpackage

>>> src/isc_pattern_mem.sv
module isc_pattern_mem import isc_pkg::*; #(
  parameter int unsigned ROWS = 8,
  parameter int unsigned COLS = 8,
  localparam int unsigned RW = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int unsigned CW = (COLS > 1) ? $clog2(COLS) : 1
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [RW-1:0]              wr_row_i,
  input  logic [CW-1:0]              wr_col_i,
  input  logic [ID_W-1:0]            wr_data_i,
  input  logic                       rd_en_i,
  input  logic [RW-1:0]              rd_row_i,
  output logic [COLS-1:0][ID_W-1:0]  rd_data_o
);

  logic [ID_W-1:0]           mem_q [ROWS][COLS];
  logic [COLS-1:0][ID_W-1:0] rd_data_q;

  // single-id write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_row_i][wr_col_i] <= wr_data_i;
    end
  end

  // whole-row registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      for (int unsigned c = 0; c < COLS; c++) begin
        rd_data_q[c] <= mem_q[rd_row_i][c];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/isc_match_unit.sv
module isc_match_unit import isc_pkg::*; #(
  parameter int unsigned COLS  = 8,
  parameter int unsigned LEN_W = 4
) (
  input  logic [COLS-1:0][ID_W-1:0] row_i,
  input  logic [ID_W-1:0]           id_i,
  input  logic [COLS-1:0]           seen_i,
  input  logic [LEN_W-1:0]          len_i,
  output logic [COLS-1:0]           seen_o,
  output logic                      full_o
);

  logic [COLS-1:0] mask;
  logic [COLS-1:0] hit;

  // one compare per slot; slots past the length never match
  always_comb begin
    for (int unsigned c = 0; c < COLS; c++) begin
      mask[c] = (32'(c) < 32'(len_i));
      hit[c]  = mask[c] && (row_i[c] == id_i);
    end
    seen_o = seen_i | hit;
    full_o = ((seen_o & mask) == mask);
  end

endmodule

>>> src/itemset_support_counter.sv
// Itemset support counter. Patterns of item ids are loaded one id per load
// transaction (tuser op = load), then transaction items stream in; a pattern
// is supported by a transaction when one of its itemsets holds every id of
// the pattern. Up to min(PATTERNS, 8) patterns are kept, and patterns_in_use
// (APB register 0) picks how many are matched and reported. Load and clear
// transactions are handled in the idle state. For a transaction item one
// shared match unit checks one pattern row per cycle for each pattern in use,
// fed by the single read port of the pattern memory, and a closing state
// updates the totals. A report emits one result per cycle while the output
// side takes them; the block takes the next input while the final result
// still waits in the output register. The pattern memory needs no clearing
// pass after reset, but a pattern slot that was never loaded reads as an
// unknown id.
module itemset_support_counter import isc_pkg::*; #(
  parameter int unsigned PATTERNS        = 8,
  parameter int unsigned MAX_PATTERN_LEN = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [2:0] pattern_index, [5:3] slot, [9:6] pattern_length,
  // [25:10] item_id, [31:26] zero
  input  logic [S_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] op, [2] end_of_itemset
  input  logic [S_TUSER_W-1:0]  s_axis_tuser_i,
  // end_of_transaction
  input  logic                  s_axis_tlast_i,
  // result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [2:0] result_pattern, [26:3] support_count, [50:27] transaction_total,
  // [55:51] zero
  output logic [M_TDATA_W-1:0]  m_axis_tdata_o,
  // last result of a report
  output logic                  m_axis_tlast_o,
  // APB register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

`include "itemset_support_counter_defines.svh"

  // only eight patterns can be addressed or reported
  localparam int unsigned ROWS  = (PATTERNS < REPORT_LIMIT) ? PATTERNS : REPORT_LIMIT;
  localparam int unsigned COLS  = MAX_PATTERN_LEN;
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned NW    = $clog2(ROWS + 1);
  localparam int unsigned LEN_W = $clog2(COLS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLOSE,
    ST_REPORT
  } state_e;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  state_e              state_q;
  logic [RW-1:0]       idx_q;
  logic [NW-1:0]       n_q;
  logic                cmp_vld_q;
  logic [RW-1:0]       cmp_idx_q;
  logic [PIU_W-1:0]    piu_q;
  logic [LEN_W-1:0]    len_q  [ROWS];
  logic [COLS-1:0]     seen_q [ROWS];
  logic [ROWS-1:0]     hit_q;
  logic [CNT_W-1:0]    cnt_q  [ROWS];
  logic [CNT_W-1:0]    total_q;
  logic [ID_W-1:0]     id_q;
  logic                eoi_q;
  logic                eot_q;
  logic                m_valid_q;
  logic [PAT_W-1:0]    out_pat_q;
  logic [CNT_W-1:0]    out_cnt_q;
  logic [CNT_W-1:0]    out_total_q;
  logic                out_last_q;

  // input field unpacking
  op_e                 s_op;
  logic                s_eoi;
  logic [PAT_W-1:0]    s_pidx;
  logic [SLOT_W-1:0]   s_slot;
  logic [LEN_IN_W-1:0] s_len;
  logic [ID_W-1:0]     s_id;
  logic                s_fire;

  assign s_op   = op_e'(s_axis_tuser_i[1:0]);
  assign s_eoi  = s_axis_tuser_i[2];
  assign s_pidx = s_axis_tdata_i[2:0];
  assign s_slot = s_axis_tdata_i[5:3];
  assign s_len  = s_axis_tdata_i[9:6];
  assign s_id   = s_axis_tdata_i[25:10];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // register port
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_PATTERNS_IN_USE) ? APB_DW'(piu_q) : '0;

  // effective pattern count: min(register, ROWS)
  logic [NW-1:0] n_act;
  always_comb begin
    if (32'(piu_q) > ROWS) begin
      n_act = NW'(ROWS);
    end else begin
      n_act = NW'(piu_q);
    end
  end

  // load decode
  logic             load_ok;
  logic [LEN_W-1:0] len_sat;
  logic [7:0]       slot_ext;
  logic             mem_we;

  assign load_ok  = (32'(s_pidx) < ROWS) && (32'(s_slot) < COLS);
  assign len_sat  = (32'(s_len) > COLS) ? LEN_W'(COLS) : LEN_W'(s_len);
  assign slot_ext = {5'b0, s_slot};
  assign mem_we   = s_fire && (s_op == OP_LOAD) && load_ok;

  logic [COLS-1:0][ID_W-1:0] row_data;

  isc_pattern_mem #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_row_i  (s_pidx[RW-1:0]),
    .wr_col_i  (slot_ext[CW-1:0]),
    .wr_data_i (s_id),
    .rd_en_i   (state_q == ST_SCAN),
    .rd_row_i  (idx_q),
    .rd_data_o (row_data)
  );

  // one read index into the per-pattern state: report walk or match stage
  logic [RW-1:0]    sel_idx;
  logic [CNT_W-1:0] cnt_sel;
  logic             hit_sel;
  logic [COLS-1:0]  seen_new;
  logic             full;
  logic             closing;
  logic             idx_last;

  assign sel_idx  = (state_q == ST_REPORT) ? idx_q : cmp_idx_q;
  assign cnt_sel  = cnt_q[sel_idx];
  assign hit_sel  = hit_q[sel_idx];
  assign closing  = eoi_q || eot_q;
  assign idx_last = ((32'(idx_q) + 32'd1) == 32'(n_q));

  isc_match_unit #(
    .COLS  (COLS),
    .LEN_W (LEN_W)
  ) u_match (
    .row_i  (row_data),
    .id_i   (id_q),
    .seen_i (seen_q[sel_idx]),
    .len_i  (len_q[sel_idx]),
    .seen_o (seen_new),
    .full_o (full)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      n_q         <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      piu_q       <= PIU_RESET;
      len_q       <= '{default: '0};
      seen_q      <= '{default: '0};
      hit_q       <= '0;
      cnt_q       <= '{default: '0};
      total_q     <= '0;
      id_q        <= '0;
      eoi_q       <= 1'b0;
      eot_q       <= 1'b0;
      m_valid_q   <= 1'b0;
      out_pat_q   <= '0;
      out_cnt_q   <= '0;
      out_total_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_we && (paddr[2] == REG_PATTERNS_IN_USE)) begin
        piu_q <= pwdata[PIU_W-1:0];
      end

      // match stage runs in the cycle after the row read
      cmp_vld_q <= (state_q == ST_SCAN);
      if (state_q == ST_SCAN) begin
        cmp_idx_q <= idx_q;
      end

      // the report walk refills the output register itself
      if (m_valid_q && m_axis_tready_i && (state_q != ST_REPORT)) begin
        m_valid_q <= 1'b0;
      end

      if (cmp_vld_q) begin
        // on the closing cycle the whole-table clears below replace these
        if (!((state_q == ST_CLOSE) && closing)) begin
          seen_q[cmp_idx_q] <= seen_new;
        end
        if (closing && full && !((state_q == ST_CLOSE) && eot_q)) begin
          hit_q[cmp_idx_q] <= 1'b1;
        end
        if (eot_q && (hit_sel || full)) begin
          cnt_q[cmp_idx_q] <= sat_inc(cnt_sel);
        end
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            unique case (s_op)
              OP_LOAD: begin
                if (load_ok) begin
                  len_q[s_pidx[RW-1:0]] <= len_sat;
                end
              end
              OP_ITEM: begin
                id_q  <= s_id;
                eoi_q <= s_eoi;
                eot_q <= s_axis_tlast_i;
                n_q   <= n_act;
                idx_q <= '0;
                state_q <= (n_act == '0) ? ST_CLOSE : ST_SCAN;
              end
              OP_REPORT: begin
                n_q   <= n_act;
                idx_q <= '0;
                if (n_act != '0) begin
                  state_q <= ST_REPORT;
                end
              end
              OP_CLEAR: begin
                cnt_q   <= '{default: '0};
                total_q <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (idx_last) begin
            state_q <= ST_CLOSE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_CLOSE: begin
          // last match result lands this cycle; it is folded into the clears
          if (closing) begin
            seen_q <= '{default: '0};
          end
          if (eot_q) begin
            hit_q   <= '0;
            total_q <= sat_inc(total_q);
          end
          state_q <= ST_IDLE;
        end
        ST_REPORT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q   <= 1'b1;
            out_pat_q   <= PAT_W'(idx_q);
            out_cnt_q   <= cnt_sel;
            out_total_q <= total_q;
            out_last_q  <= idx_last;
            if (idx_last) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_total_q, out_cnt_q, out_pat_q};
  assign m_axis_tlast_o  = out_last_q;

  // match stage only follows a row read
  `ISC_ASSERT_IMPL(a_cmp_in_scan, cmp_vld_q, (state_q == ST_SCAN) || (state_q == ST_CLOSE))
  // scan never walks past the latched pattern count
  `ISC_ASSERT_IMPL(a_scan_range, state_q == ST_SCAN, 32'(idx_q) < 32'(n_q))
  // no pattern can be supported more often than transactions were seen
  `ISC_ASSERT_IMPL(a_count_le_total, state_q == ST_REPORT, cnt_sel <= total_q)
  // transaction end leaves no stale hit
  `ISC_ASSERT_NEXT(a_hit_cleared, (state_q == ST_CLOSE) && eot_q, hit_q == '0)

endmodule
